// ===== rtl/atsfp_pkg.sv =====
// ----------------------------------------------------------------------------
// atsfp_pkg
// Shared types, constants and helpers for the animal tag frame parser.
// ----------------------------------------------------------------------------
package atsfp_pkg;

    localparam logic [7:0] START_BYTE = 8'h02;
    localparam logic [7:0] END_OK     = 8'h07;
    localparam logic [7:0] END_ALT    = 8'h03;

    localparam int TAG_W     = 40;
    localparam int COUNTRY_W = 16;
    localparam int ANIMAL_W  = 4;
    localparam int STATUS_W  = 3;
    localparam int POS_W     = 5;
    localparam int M_TDATA_W = 64;

    localparam logic [POS_W-1:0] POS_TAG_LO     = 5'd1;
    localparam logic [POS_W-1:0] POS_TAG_HI     = 5'd10;
    localparam logic [POS_W-1:0] POS_COUNTRY_LO = 5'd11;
    localparam logic [POS_W-1:0] POS_COUNTRY_HI = 5'd14;
    localparam logic [POS_W-1:0] POS_ANIMAL     = 5'd16;
    localparam logic [POS_W-1:0] POS_XOR_HI     = 5'd26;
    localparam logic [POS_W-1:0] POS_CHECK      = 5'd27;
    localparam logic [POS_W-1:0] POS_INV_CHECK  = 5'd28;
    localparam logic [POS_W-1:0] POS_LAST       = 5'd29;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CSUM_BAD = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INV_BAD  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_END_ALT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_END_FDX  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd5;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [TAG_W-1:0]     tag_id;
        logic [COUNTRY_W-1:0] country_id;
        logic [ANIMAL_W-1:0]  animal_flag;
    } t_result;

    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [3:0] d;
        d = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            d = c[3:0] + 4'd9;
        end
        return d;
    endfunction

endpackage

// ===== rtl/atsfp_frame.sv =====
// ----------------------------------------------------------------------------
// atsfp_frame
// Frame state and accumulators; flags a result when a frame ends or aborts.
// ----------------------------------------------------------------------------
module atsfp_frame (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_op,
    input  logic [7:0]          i_byte,
    output logic                o_res_valid,
    output atsfp_pkg::t_result  o_res
);
    import atsfp_pkg::*;

    logic                 r_in_frame,    n_in_frame;
    logic [POS_W-1:0]     r_pos,         n_pos;
    logic [7:0]           r_xor,         n_xor;
    logic                 r_csum_ok,     n_csum_ok;
    logic                 r_inv_ok,      n_inv_ok;
    logic [TAG_W-1:0]     r_tag,         n_tag;
    logic [COUNTRY_W-1:0] r_country,     n_country;
    logic [ANIMAL_W-1:0]  r_animal,      n_animal;

    logic [3:0] digit;
    logic       done;

    always_comb begin
        digit       = hex_digit(i_byte);
        n_in_frame  = r_in_frame;
        n_pos       = r_pos;
        n_xor       = r_xor;
        n_csum_ok   = r_csum_ok;
        n_inv_ok    = r_inv_ok;
        n_tag       = r_tag;
        n_country   = r_country;
        n_animal    = r_animal;
        done        = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_op == OP_TIMEOUT) begin
            if (r_in_frame) begin
                o_res_valid = 1'b1;
                o_res.status = ST_SHORT;
                done = 1'b1;
            end
        end else if (!r_in_frame) begin
            if (i_byte == START_BYTE) begin
                n_in_frame = 1'b1;
                n_pos      = POS_TAG_LO;
            end
        end else begin
            // digits arrive least significant first: shift in at the top
            if (r_pos >= POS_TAG_LO && r_pos <= POS_TAG_HI) begin
                n_tag = {digit, r_tag[TAG_W-1:4]};
            end else if (r_pos >= POS_COUNTRY_LO && r_pos <= POS_COUNTRY_HI) begin
                n_country = {digit, r_country[COUNTRY_W-1:4]};
            end else if (r_pos == POS_ANIMAL) begin
                n_animal = digit;
            end

            if (r_pos <= POS_XOR_HI) begin
                n_xor = r_xor ^ i_byte;
            end else if (r_pos == POS_CHECK) begin
                n_csum_ok = (i_byte == r_xor);
            end else if (r_pos == POS_INV_CHECK) begin
                n_inv_ok = (i_byte == ~r_xor);
            end

            if (r_pos < POS_LAST) begin
                n_pos = r_pos + 1'b1;
            end else begin
                o_res_valid = 1'b1;
                done        = 1'b1;
                if (!r_csum_ok) begin
                    o_res.status = ST_CSUM_BAD;
                end else if (!r_inv_ok) begin
                    o_res.status = ST_INV_BAD;
                end else if (i_byte == END_ALT) begin
                    o_res.status = ST_END_ALT;
                end else if (i_byte != END_OK) begin
                    o_res.status = ST_END_FDX;
                end else begin
                    o_res.status      = ST_OK;
                    o_res.tag_id      = r_tag;
                    o_res.country_id  = r_country;
                    o_res.animal_flag = r_animal;
                end
            end
        end

        if (done) begin
            n_in_frame = 1'b0;
            n_pos      = '0;
            n_xor      = '0;
            n_csum_ok  = 1'b0;
            n_inv_ok   = 1'b0;
            n_tag      = '0;
            n_country  = '0;
            n_animal   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pos      <= '0;
            r_xor      <= '0;
            r_csum_ok  <= 1'b0;
            r_inv_ok   <= 1'b0;
            r_tag      <= '0;
            r_country  <= '0;
            r_animal   <= '0;
        end else if (i_en) begin
            r_in_frame <= n_in_frame;
            r_pos      <= n_pos;
            r_xor      <= n_xor;
            r_csum_ok  <= n_csum_ok;
            r_inv_ok   <= n_inv_ok;
            r_tag      <= n_tag;
            r_country  <= n_country;
            r_animal   <= n_animal;
        end
    end

endmodule

// ===== rtl/animal_tag_serial_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// animal_tag_serial_frame_parser_top
// Parses 30-byte ASCII animal tag reader frames, one received byte per item.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle unless the result side stalls. Each item
// passes an input register and is then handled by the frame logic, whose
// result lands in an output register; a result follows the byte that ends
// its frame (byte 29) or a timeout that aborts a partial frame. Bytes before
// a start byte and timeouts outside a frame give no result. Backpressure on
// the result side holds the input register, and input acceptance stops only
// while a result waits and the input register is full.
module animal_tag_serial_frame_parser_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [7:0]                           i_s_tdata,  // [7:0] data_byte
    input  logic                                 i_s_tuser,  // [0] op
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [39:0] tag_id, [55:40] country_id, [59:56] animal_flag, [63:60] zero
    output logic [atsfp_pkg::M_TDATA_W-1:0]      o_m_tdata,
    output logic [atsfp_pkg::STATUS_W-1:0]       o_m_tuser   // [2:0] status
);
    import atsfp_pkg::*;

    logic       r_in_valid;
    logic       r_in_op;
    logic [7:0] r_in_byte;
    logic       advance;
    logic       res_valid;
    t_result    res;
    t_result    r_res;
    logic       r_out_valid;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_op   <= i_s_tuser;
            r_in_byte <= i_s_tdata;
        end
    end

    atsfp_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_op        (r_in_op),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_m_tready) begin
            r_out_valid <= advance && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_res <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_res.status;
    assign o_m_tdata  = {{(M_TDATA_W - TAG_W - COUNTRY_W - ANIMAL_W){1'b0}},
                         r_res.animal_flag, r_res.country_id, r_res.tag_id};

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the animal tag reader frame parser.
// ----------------------------------------------------------------------------
// A queue of byte and timeout items feeds a bursty stream driver. Each
// accepted item also steps a frame parser model kept in the bench, which
// queues the report the block should send. A monitor behind a stalling
// receiver checks every report, field by field, against that queue.
// Stimulus is a few hand-built frames first. Random frames follow, most of
// them well formed and the rest with checksum, inverse check, end byte or
// timeout faults, plus line noise.
// ----------------------------------------------------------------------------
module tb;
    import atsfp_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1150;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 10;

    typedef struct packed {
        logic       hold;
        logic       op;
        logic [7:0] data;
    } feed_item_t;

    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [7:0]           i_s_tdata  = 8'h00;  // [7:0] data_byte
    logic                 i_s_tuser  = 1'b0;   // [0] op
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    // [39:0] tag_id, [55:40] country_id, [59:56] animal_flag, [63:60] zero
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [STATUS_W-1:0]  o_m_tuser;            // [2:0] status

    feed_item_t  feed_items[$];
    t_result     reports_due[$];
    logic [7:0]  body_buf[1:26];
    int unsigned live_items;
    int unsigned mismatches;
    int unsigned cycles;
    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned stall_mode;
    int unsigned stall_tick;

    // frame parser state
    logic                 fp_in_frame;
    logic [POS_W-1:0]     fp_pos;
    logic [7:0]           fp_xor;
    logic                 fp_sum_ok;
    logic                 fp_inv_ok;
    logic [TAG_W-1:0]     fp_tag;
    logic [COUNTRY_W-1:0] fp_country;
    logic [ANIMAL_W-1:0]  fp_animal;

    animal_tag_serial_frame_parser_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [3:0] ascii_to_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return 4'(c - 8'h30);
        end
        if (c >= "a" && c <= "f") begin
            return 4'(c - 8'h57);
        end
        if (c >= "A" && c <= "F") begin
            return 4'(c - 8'h37);
        end
        return 4'd0;
    endfunction

    task automatic drop_frame();
        fp_in_frame = 1'b0;
        fp_pos      = '0;
        fp_xor      = '0;
        fp_sum_ok   = 1'b0;
        fp_inv_ok   = 1'b0;
        fp_tag      = '0;
        fp_country  = '0;
        fp_animal   = '0;
    endtask

    task automatic parse_frame_item(input logic op, input logic [7:0] b);
        t_result rep;
        int      p;
        rep = '0;
        if (op == OP_TIMEOUT) begin
            if (fp_in_frame) begin
                rep.status = ST_SHORT;
                reports_due.push_back(rep);
                drop_frame();
            end
            return;
        end
        if (!fp_in_frame) begin
            if (b == START_BYTE) begin
                drop_frame();
                fp_in_frame = 1'b1;
                fp_pos      = POS_TAG_LO;
            end
            return;
        end
        p = int'(fp_pos);
        if (p >= 1 && p <= 10) begin
            fp_tag[(p - 1) * 4 +: 4] = ascii_to_nibble(b);
        end else if (p >= 11 && p <= 14) begin
            fp_country[(p - 11) * 4 +: 4] = ascii_to_nibble(b);
        end else if (p == 16) begin
            fp_animal = ascii_to_nibble(b);
        end
        if (p <= 26) begin
            fp_xor = fp_xor ^ b;
        end else if (p == 27) begin
            fp_sum_ok = (b == fp_xor);
        end else if (p == 28) begin
            fp_inv_ok = (b == ~fp_xor);
        end
        if (p < 29) begin
            fp_pos = fp_pos + 1'b1;
            return;
        end
        if (!fp_sum_ok) begin
            rep.status = ST_CSUM_BAD;
        end else if (!fp_inv_ok) begin
            rep.status = ST_INV_BAD;
        end else if (b == END_ALT) begin
            rep.status = ST_END_ALT;
        end else if (b != END_OK) begin
            rep.status = ST_END_FDX;
        end else begin
            rep.status      = ST_OK;
            rep.tag_id      = fp_tag;
            rep.country_id  = fp_country;
            rep.animal_flag = fp_animal;
        end
        reports_due.push_back(rep);
        drop_frame();
    endtask

    // stimulus helpers
    task automatic queue_byte(input logic [7:0] b, input bit counted);
        feed_items.push_back('{1'b0, OP_BYTE, b});
        if (counted) begin
            live_items++;
        end
    endtask

    task automatic queue_timeout(input bit counted);
        feed_items.push_back('{1'b0, OP_TIMEOUT, 8'($urandom_range(0, 255))});
        if (counted) begin
            live_items++;
        end
    endtask

    task automatic queue_hold();
        feed_items.push_back('{1'b1, OP_BYTE, 8'h00});
    endtask

    function automatic logic [7:0] pick_hex_char();
        int unsigned r;
        r = $urandom_range(0, 21);
        if (r < 10) begin
            return 8'(8'h30 + r);
        end
        if (r < 16) begin
            return 8'(8'h61 + r - 10);
        end
        return 8'(8'h41 + r - 16);
    endfunction

    task automatic fill_random_body();
        for (int i = 1; i <= 26; i++) begin
            if ((i <= 14 || i == 16) && $urandom_range(0, 7) != 0) begin
                body_buf[i] = pick_hex_char();
            end else begin
                body_buf[i] = 8'($urandom_range(0, 255));
            end
        end
    endtask

    task automatic set_body_text(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            body_buf[i + 1] = txt[i];
        end
    endtask

    task automatic send_frame(input bit bad_sum, input bit bad_inv,
                              input logic [7:0] last_byte);
        logic [7:0] sum;
        sum = 8'h00;
        queue_byte(START_BYTE, 1'b1);
        for (int i = 1; i <= 26; i++) begin
            sum = sum ^ body_buf[i];
            queue_byte(body_buf[i], 1'b1);
        end
        queue_byte(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum, 1'b1);
        queue_byte(bad_inv ? ~sum ^ 8'($urandom_range(1, 255)) : ~sum, 1'b1);
        queue_byte(last_byte, 1'b1);
    endtask

    task automatic send_short(input int unsigned n, input bit with_timeout);
        queue_byte(START_BYTE, 1'b1);
        for (int unsigned i = 0; i < n; i++) begin
            queue_byte(8'($urandom_range(0, 255)), 1'b1);
        end
        if (with_timeout) begin
            queue_timeout(1'b1);
        end
    endtask

    task automatic send_noise(input int unsigned n);
        logic [7:0] b;
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                queue_timeout(1'b0);
            end else begin
                b = 8'($urandom_range(0, 255));
                if (b == START_BYTE) begin
                    b = 8'hFD;
                end
                queue_byte(b, 1'b0);
            end
        end
    endtask

    function automatic logic [7:0] pick_bad_end();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == END_OK || b == END_ALT) begin
            b = ~b;
        end
        return b;
    endfunction

    task automatic build_stimulus();
        int unsigned kind;
        // ignored items outside a frame
        queue_timeout(1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        // field extremes, both letter cases
        fill_random_body();
        set_body_text("FFFFFFFFFFFFFF.F");
        send_frame(1'b0, 1'b0, END_OK);
        fill_random_body();
        set_body_text("00000000000000.0");
        send_frame(1'b0, 1'b0, END_OK);
        fill_random_body();
        set_body_text("0123456789abcd-e");
        send_frame(1'b0, 1'b0, END_OK);
        // non-hex characters in digit slots
        fill_random_body();
        set_body_text("/:@G`gz A9x:[]~Z");
        body_buf[8] = 8'hFF;
        body_buf[9] = 8'h00;
        send_frame(1'b0, 1'b0, END_OK);
        // start byte inside a frame is data
        fill_random_body();
        body_buf[1]  = START_BYTE;
        body_buf[20] = START_BYTE;
        send_frame(1'b0, 1'b0, END_OK);
        // check priority
        fill_random_body();
        send_frame(1'b1, 1'b1, 8'h55);
        fill_random_body();
        send_frame(1'b0, 1'b1, END_ALT);
        fill_random_body();
        send_frame(1'b0, 1'b0, END_ALT);
        fill_random_body();
        send_frame(1'b0, 1'b0, 8'h00);
        fill_random_body();
        send_frame(1'b0, 1'b0, 8'hFF);
        // aborted frames
        send_short(0, 1'b1);
        send_short(5, 1'b1);
        send_short(28, 1'b1);
        queue_hold();

        while (live_items < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            fill_random_body();
            if (kind < 58) begin
                send_frame(1'b0, 1'b0, END_OK);
            end else if (kind < 65) begin
                send_frame(1'b1, 1'($urandom_range(0, 1)), pick_bad_end());
            end else if (kind < 71) begin
                send_frame(1'b0, 1'b1, $urandom_range(0, 1) ? END_OK : pick_bad_end());
            end else if (kind < 76) begin
                send_frame(1'b0, 1'b0, END_ALT);
            end else if (kind < 81) begin
                send_frame(1'b0, 1'b0, pick_bad_end());
            end else if (kind < 89) begin
                send_short($urandom_range(0, 28), 1'b1);
            end else if (kind < 92) begin
                // cut frame swallowed by the next one, then realigned
                send_short($urandom_range(0, 20), 1'b0);
                send_frame(1'b0, 1'b0, END_OK);
                queue_timeout(1'b1);
            end else if (kind < 97) begin
                send_noise($urandom_range(1, 8));
            end else begin
                queue_hold();
            end
        end
    endtask

    // stream driver
    always @(posedge i_clk) begin : drive_proc
        feed_item_t nxt;
        logic       nv;
        logic [7:0] nd;
        logic       nu;
        nv = i_s_tvalid;
        nd = i_s_tdata;
        nu = i_s_tuser;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                parse_frame_item(i_s_tuser, i_s_tdata);
                nv = 1'b0;
            end
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (feed_items.size() > 0) begin
                    if (feed_items[0].hold) begin
                        if (reports_due.size() == 0) begin
                            void'(feed_items.pop_front());
                        end
                    end else begin
                        nxt = feed_items.pop_front();
                        nv  = 1'b1;
                        nd  = nxt.data;
                        nu  = nxt.op;
                        if (burst_left > 0) begin
                            burst_left--;
                        end else begin
                            burst_left = ($urandom_range(0, 3) == 0) ?
                                         $urandom_range(50, 200) : $urandom_range(1, 12);
                            gap_left   = ($urandom_range(0, 4) == 0) ?
                                         $urandom_range(5, 20) : $urandom_range(0, 3);
                        end
                    end
                end
            end
        end
        i_s_tvalid <= nv;
        i_s_tdata  <= nd;
        i_s_tuser  <= nu;
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // report monitor and receiver stalls
    always @(posedge i_clk) begin : watch_proc
        t_result want;
        logic    rdy;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (reports_due.size() == 0) begin
                $display("%0t: unexpected report, expected none actual status %h tdata %h",
                         $time, o_m_tuser, o_m_tdata);
                mismatches++;
            end else begin
                want = reports_due.pop_front();
                check_field("status", 64'(want.status), 64'(o_m_tuser));
                check_field("tag_id", 64'(want.tag_id), 64'(o_m_tdata[39:0]));
                check_field("country_id", 64'(want.country_id), 64'(o_m_tdata[55:40]));
                check_field("animal_flag", 64'(want.animal_flag), 64'(o_m_tdata[59:56]));
                check_field("tdata pad", 64'(0), 64'(o_m_tdata[63:60]));
            end
        end
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = (stall_mode == 3) ? $urandom_range(5, 40) : $urandom_range(20, 150);
        end else begin
            stall_left--;
        end
        stall_tick++;
        case (stall_mode)
            0: rdy = 1'b1;
            1: rdy = ($urandom_range(0, 1) == 1);
            2: rdy = (stall_tick % 4 == 0);
            default: rdy = 1'b0;
        endcase
        i_m_tready <= rdy;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        live_items  = 0;
        mismatches  = 0;
        cycles      = 0;
        burst_left  = 0;
        gap_left    = 0;
        stall_left  = 0;
        stall_mode  = 0;
        stall_tick  = 0;
        drop_frame();
        build_stimulus();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        while (feed_items.size() > 0 || i_s_tvalid || reports_due.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && reports_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/atsfp_pkg.sv
rtl/atsfp_frame.sv
rtl/animal_tag_serial_frame_parser_top.sv
verif/tb.sv
